@@ design/ocos_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ocos_pkg: shared constants and types for the omni chassis odometry step
// Holds stream packing widths, register codes and fixed-point constants.
// ----------------------------------------------------------------------------
package ocos_pkg;

  localparam int unsigned MAX_WHEELS  = 4;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned ROW_W       = 64;
  localparam int unsigned Q_W         = 32;
  localparam int unsigned DELTA_W     = 19;

  localparam int unsigned IN_DATA_W   = 96;
  localparam int unsigned IN_USER_W   = 7;
  localparam int unsigned OUT_DATA_W  = 128;

  // tuser bit positions, lowest bit first
  localparam int unsigned USER_ENABLE_BIT = 0;
  localparam int unsigned USER_MASK_LSB   = 1;
  localparam int unsigned USER_YAW_V_BIT  = 5;
  localparam int unsigned USER_RATE_V_BIT = 6;

  // tdata offsets of the IMU samples
  localparam int unsigned DATA_YAW_LSB  = 64;
  localparam int unsigned DATA_RATE_LSB = 80;

  // Register map: rows at byte 0 and 8, bit 3 picks the row
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_SEL_BIT = 3;

  typedef enum logic {
    REG_VX_ROW = 1'b0,
    REG_VY_ROW = 1'b1
  } cfg_reg_t;

  // Yaw in 1/64 degree: half turn is 180 degrees
  localparam logic signed [DELTA_W-1:0] YAW_HALF_TURN  = 19'sd11520;
  localparam logic signed [DELTA_W-1:0] YAW_FULL_TURN  = 19'sd23040;
  localparam logic signed [DELTA_W-1:0] YAW_THREE_HALF = 19'sd34560;
  localparam logic signed [DELTA_W-1:0] YAW_FIVE_HALF  = 19'sd57600;
  localparam logic signed [DELTA_W-1:0] YAW_TWO_TURN   = 19'sd46080;
  localparam logic signed [DELTA_W-1:0] YAW_THREE_TURN = 19'sd69120;

  // round(2^32*pi/11520) and round(2^32*pi/2880)
  localparam logic [20:0] YAW_TO_RAD_Q  = 21'd1171271;
  localparam logic [22:0] RATE_TO_RAD_Q = 23'd4685083;

  // Fold a raw yaw difference into [-half turn, +half turn]; edges stay.
  function automatic logic signed [DELTA_W-1:0] wrap_yaw_delta(
    input logic signed [DELTA_W-1:0] d
  );
    logic signed [DELTA_W-1:0] r;
    if (d > YAW_FIVE_HALF) begin
      r = d - YAW_THREE_TURN;
    end else if (d > YAW_THREE_HALF) begin
      r = d - YAW_TWO_TURN;
    end else if (d > YAW_HALF_TURN) begin
      r = d - YAW_FULL_TURN;
    end else if (d < -YAW_FIVE_HALF) begin
      r = d + YAW_THREE_TURN;
    end else if (d < -YAW_THREE_HALF) begin
      r = d + YAW_TWO_TURN;
    end else if (d < -YAW_HALF_TURN) begin
      r = d + YAW_FULL_TURN;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/omni_chassis_odometry_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// omni_chassis_odometry_step: omni-wheel forward kinematics with yaw unwrap
// Turns wheel speeds and IMU yaw/rate samples into Q16.16 vx, vy, yaw, rate.
// ----------------------------------------------------------------------------
// Each input beat carries up to four wheel speeds (1/16 rpm) with a fresh
// mask, plus an optional yaw sample (1/64 degree) and yaw rate (1/16 deg/s).
// A wheel or rate that is not fresh reuses its held value. vx and vy are dot
// products of the held speeds with the two coefficient rows written through
// the APB port (row 0 at byte 0, row 1 at byte 8, each 64 bits holding four
// signed 16-bit coefficients). The first valid yaw seeds the accumulator;
// later deltas are folded to +-180 degrees and added with saturation. A beat
// with step_enable low is taken and dropped: no result, no state change.
// The block takes one beat per cycle while the output is not stalled. An
// enabled beat passes an input register, a stage that updates the held state
// and forms the products, and the result register, which holds its result
// beat. Stages advance independently, so input is still taken while a result
// waits at the output, until the input register and stage 2 are full.
// Write the coefficient rows only while the block is empty.
module omni_chassis_odometry_step
  import ocos_pkg::*;
#(
  parameter int unsigned WHEEL_COUNT = 4   // 3 or 4 wheels
) (
  input  wire                         clk,
  input  wire                         rst_n,
  // input stream
  input  wire                         in_tvalid,
  output logic                        in_tready,
  // [15:0] wheel_speed_a, [31:16] wheel_speed_b, [47:32] wheel_speed_c,
  // [63:48] wheel_speed_d, [79:64] yaw_raw, [95:80] rate_raw
  input  wire  [IN_DATA_W-1:0]        in_tdata,
  // [0] step_enable, [4:1] wheel_valid_mask, [5] yaw_valid, [6] rate_valid
  input  wire  [IN_USER_W-1:0]        in_tuser,
  // result stream
  output logic                        out_tvalid,
  input  wire                         out_tready,
  // [31:0] velocity_x, [63:32] velocity_y, [95:64] yaw_unwrapped,
  // [127:96] yaw_rate
  output logic [OUT_DATA_W-1:0]       out_tdata,
  // configuration
  input  wire                         cfg_psel,
  input  wire                         cfg_penable,
  input  wire                         cfg_pwrite,
  input  wire  [CFG_ADDR_W-1:0]       cfg_paddr,
  input  wire  [ROW_W-1:0]            cfg_pwdata,
  output logic [ROW_W-1:0]            cfg_prdata,
  output logic                        cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] vx_row_r;
  logic [ROW_W-1:0] vy_row_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_row_r <= '0;
      vy_row_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_paddr[CFG_SEL_BIT]))
        REG_VX_ROW: vx_row_r <= cfg_pwdata;
        REG_VY_ROW: vy_row_r <= cfg_pwdata;
        default:    vx_row_r <= vx_row_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(cfg_paddr[CFG_SEL_BIT]))
      REG_VX_ROW: cfg_prdata = vx_row_r;
      REG_VY_ROW: cfg_prdata = vy_row_r;
      default:    cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage handshakes: each stage loads when empty or when its data moves on
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic s2_rdy, s3_rdy;
  logic in_beat, s2_load, s3_load;

  assign s3_rdy    = !out_v_r || out_tready;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign in_tready = !s1_v_r || s2_rdy;
  assign in_beat   = in_tvalid && in_tready;
  assign s2_load   = s1_v_r && s2_rdy;
  assign s3_load   = s2_v_r && s3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      // drop beats with step_enable low right here
      if (in_beat) begin
        s1_v_r <= in_tuser[USER_ENABLE_BIT];
      end else if (s2_rdy) begin
        s1_v_r <= 1'b0;
      end
      if (s2_load) begin
        s2_v_r <= 1'b1;
      end else if (s3_rdy) begin
        s2_v_r <= 1'b0;
      end
      if (s3_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic [IN_DATA_W-1:0] s1_data_r;
  logic [IN_USER_W-1:0] s1_user_r;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_data_r <= in_tdata;
      s1_user_r <= in_tuser;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: update held state, form products
  // --------------------------------------------------------------------------
  logic signed [SPEED_W-1:0] held_r   [WHEEL_COUNT];
  logic signed [SPEED_W-1:0] held_nxt [WHEEL_COUNT];
  logic                      yaw_seeded_r;
  logic signed [SPEED_W-1:0] prev_yaw_r;
  logic signed [Q_W-1:0]     yaw_acc_r;
  logic signed [Q_W-1:0]     yaw_acc_nxt;
  logic signed [Q_W-1:0]     held_rate_r;
  logic signed [Q_W-1:0]     held_rate_nxt;

  logic signed [PROD_W-1:0]  prod_x_nxt [WHEEL_COUNT];
  logic signed [PROD_W-1:0]  prod_y_nxt [WHEEL_COUNT];
  logic signed [PROD_W-1:0]  prod_x_r   [WHEEL_COUNT];
  logic signed [PROD_W-1:0]  prod_y_r   [WHEEL_COUNT];
  logic signed [Q_W-1:0]     s2_yaw_acc_r;
  logic signed [Q_W-1:0]     s2_rate_r;

  logic                      s1_yaw_v, s1_rate_v;
  logic signed [SPEED_W-1:0] s1_yaw_raw, s1_rate_raw;
  logic signed [DELTA_W-1:0] yaw_delta, yaw_wrapped;
  logic signed [Q_W:0]       acc_sum;
  logic signed [39:0]        rate_prod, rate_rnd;

  assign s1_yaw_v    = s1_user_r[USER_YAW_V_BIT];
  assign s1_rate_v   = s1_user_r[USER_RATE_V_BIT];
  assign s1_yaw_raw  = s1_data_r[DATA_YAW_LSB +: SPEED_W];
  assign s1_rate_raw = s1_data_r[DATA_RATE_LSB +: SPEED_W];

  always_comb begin
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      held_nxt[i]   = s1_user_r[USER_MASK_LSB + i] ? s1_data_r[i*SPEED_W +: SPEED_W]
                                                   : held_r[i];
      prod_x_nxt[i] = $signed(vx_row_r[i*COEF_W +: COEF_W]) * held_nxt[i];
      prod_y_nxt[i] = $signed(vy_row_r[i*COEF_W +: COEF_W]) * held_nxt[i];
    end
  end

  // Yaw unwrap: fold the delta, add with saturation
  always_comb begin
    yaw_delta   = DELTA_W'(s1_yaw_raw) - DELTA_W'(prev_yaw_r);
    yaw_wrapped = wrap_yaw_delta(yaw_delta);
    acc_sum     = (Q_W+1)'(yaw_acc_r) + (Q_W+1)'(yaw_wrapped);
    if (!s1_yaw_v) begin
      yaw_acc_nxt = yaw_acc_r;
    end else if (!yaw_seeded_r) begin
      yaw_acc_nxt = Q_W'(s1_yaw_raw);
    end else if (acc_sum[Q_W] != acc_sum[Q_W-1]) begin
      yaw_acc_nxt = acc_sum[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end else begin
      yaw_acc_nxt = acc_sum[Q_W-1:0];
    end
  end

  // Rate to rad/s; the rounded value always fits in 24 bits
  assign rate_prod     = s1_rate_raw * $signed({1'b0, RATE_TO_RAD_Q});
  assign rate_rnd      = rate_prod + 40'sd32768;
  assign held_rate_nxt = s1_rate_v ? Q_W'($signed(rate_rnd[39:16])) : held_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WHEEL_COUNT; i++) begin
        held_r[i] <= '0;
      end
      yaw_seeded_r <= 1'b0;
      prev_yaw_r   <= '0;
      yaw_acc_r    <= '0;
      held_rate_r  <= '0;
    end else if (s2_load) begin
      held_r      <= held_nxt;
      yaw_acc_r   <= yaw_acc_nxt;
      held_rate_r <= held_rate_nxt;
      if (s1_yaw_v) begin
        yaw_seeded_r <= 1'b1;
        prev_yaw_r   <= s1_yaw_raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      prod_x_r     <= prod_x_nxt;
      prod_y_r     <= prod_y_nxt;
      s2_yaw_acc_r <= yaw_acc_nxt;
      s2_rate_r    <= held_rate_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum, round, scale yaw, result register
  // --------------------------------------------------------------------------
  logic signed [34:0] dot_x, dot_y;
  logic signed [Q_W-1:0] vel_x, vel_y, yaw_out;
  logic signed [53:0] yaw_prod, yaw_rnd;
  logic signed [37:0] yaw_q;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_comb begin
    dot_x = 35'sd8;
    dot_y = 35'sd8;
    for (int i = 0; i < WHEEL_COUNT; i++) begin
      dot_x = dot_x + 35'(prod_x_r[i]);
      dot_y = dot_y + 35'(prod_y_r[i]);
    end
    // |sum| / 16 stays within 2^28: no saturation needed
    vel_x = Q_W'($signed(dot_x[34:4]));
    vel_y = Q_W'($signed(dot_y[34:4]));
  end

  assign yaw_prod = s2_yaw_acc_r * $signed({1'b0, YAW_TO_RAD_Q});
  assign yaw_rnd  = yaw_prod + 54'sd32768;
  assign yaw_q    = yaw_rnd[53:16];

  always_comb begin
    if (yaw_q[37:Q_W-1] == {(38-Q_W+1){yaw_q[37]}}) begin
      yaw_out = yaw_q[Q_W-1:0];
    end else begin
      yaw_out = yaw_q[37] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      out_data_r <= {s2_rate_r, yaw_out, vel_y, vel_x};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_seed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    yaw_seeded_r |=> yaw_seeded_r)
    else $error("yaw seed flag dropped");

  a_delta_folded: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && s1_yaw_v && yaw_seeded_r) |->
      (yaw_wrapped <= YAW_HALF_TURN) && (yaw_wrapped >= -YAW_HALF_TURN))
    else $error("folded yaw delta outside half turn");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s3_rdy) |=> s2_v_r && $stable(s2_yaw_acc_r) && $stable(s2_rate_r))
    else $error("stage 2 lost data under stall");

  a_enabled_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_tuser[USER_ENABLE_BIT]) |=> s1_v_r)
    else $error("enabled beat not captured");

endmodule
`default_nettype wire
